[hw/rtl/modexp_pkg.sv]
`timescale 1ns / 1ps
package modexp_pkg;

  localparam int OPERAND_WIDTH_DEF = 16;

  localparam int REG_MODULUS  = 0;
  localparam int REG_EXPONENT = 1;

  localparam int MODULUS_RESET  = 1;
  localparam int EXPONENT_RESET = 0;

endpackage

[hw/rtl/modexp_mulmod.sv]
`timescale 1ns / 1ps
module modexp_mulmod #(
  parameter int WIDTH    = 16,
  parameter int SB_WIDTH = 32
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                en,
  input  logic                in_vld,
  input  logic [WIDTH-1:0]    in_a,
  input  logic [WIDTH-1:0]    in_b,
  input  logic [WIDTH-1:0]    in_n,
  input  logic [SB_WIDTH-1:0] in_sb,
  output logic                out_vld,
  output logic [WIDTH-1:0]    out_p,
  output logic [WIDTH-1:0]    out_n,
  output logic [SB_WIDTH-1:0] out_sb
);

  // a*b mod n, one multiplier bit per stage, msb first; n == 0 wraps
  function automatic logic [WIDTH-1:0] add_mod(
    input logic [WIDTH-1:0] x,
    input logic [WIDTH-1:0] y,
    input logic [WIDTH-1:0] n
  );
    logic [WIDTH:0] s;
    logic [WIDTH:0] d;
    s = {1'b0, x} + {1'b0, y};
    d = s - {1'b0, n};
    if ((n != '0) && (s >= {1'b0, n})) begin
      add_mod = d[WIDTH-1:0];
    end else begin
      add_mod = s[WIDTH-1:0];
    end
  endfunction

  logic                v_r  [0:WIDTH-1];
  logic [WIDTH-1:0]    p_r  [0:WIDTH-1];
  logic [WIDTH-1:0]    a_r  [0:WIDTH-1];
  logic [WIDTH-1:0]    b_r  [0:WIDTH-1];
  logic [WIDTH-1:0]    n_r  [0:WIDTH-1];
  logic [SB_WIDTH-1:0] sb_r [0:WIDTH-1];

  genvar k;
  generate
    for (k = 0; k < WIDTH; k++) begin : g_stage
      logic                v_prev;
      logic [WIDTH-1:0]    p_prev;
      logic [WIDTH-1:0]    a_prev;
      logic [WIDTH-1:0]    b_prev;
      logic [WIDTH-1:0]    n_prev;
      logic [SB_WIDTH-1:0] sb_prev;
      logic [WIDTH-1:0]    dbl;
      logic [WIDTH-1:0]    p_nxt;

      if (k == 0) begin : g_first
        assign v_prev  = in_vld;
        assign p_prev  = '0;
        assign a_prev  = in_a;
        assign b_prev  = in_b;
        assign n_prev  = in_n;
        assign sb_prev = in_sb;
      end else begin : g_next
        assign v_prev  = v_r[k-1];
        assign p_prev  = p_r[k-1];
        assign a_prev  = a_r[k-1];
        assign b_prev  = b_r[k-1];
        assign n_prev  = n_r[k-1];
        assign sb_prev = sb_r[k-1];
      end

      always_comb begin
        dbl   = add_mod(p_prev, p_prev, n_prev);
        p_nxt = b_prev[WIDTH-1-k] ? add_mod(dbl, a_prev, n_prev) : dbl;
      end

      always_ff @(posedge clk) begin
        if (!rst_n) begin
          v_r[k] <= 1'b0;
        end else if (en) begin
          v_r[k] <= v_prev;
        end
      end

      always_ff @(posedge clk) begin
        if (en) begin
          p_r[k]  <= p_nxt;
          a_r[k]  <= a_prev;
          b_r[k]  <= b_prev;
          n_r[k]  <= n_prev;
          sb_r[k] <= sb_prev;
        end
      end
    end
  endgenerate

  assign out_vld = v_r[WIDTH-1];
  assign out_p   = p_r[WIDTH-1];
  assign out_n   = n_r[WIDTH-1];
  assign out_sb  = sb_r[WIDTH-1];

endmodule

[hw/rtl/modular_exponentiation.sv]
`timescale 1ns / 1ps
// channel  | beat                 | handshake
// in_      | in_message_value     | in_valid / in_stall
// out_     | out_power_result     | out_valid / out_stall
// cfg      | modulus, exponent    | APB write and read, pready tied high
//
// One beat enters per cycle while the output is not stalled (W = OPERAND_WIDTH):
// W stages reduce the message mod n, then W rounds of square and multiply,
// each a W-stage bit-serial modular multiplier. Config is sampled at entry.
// A stalled output freezes the whole pipeline. Reset clears valid bits and loads the config reset values.
module modular_exponentiation
  import modexp_pkg::*;
#(
  parameter int OPERAND_WIDTH = OPERAND_WIDTH_DEF
) (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     in_valid,
  output logic                     in_stall,
  input  logic [OPERAND_WIDTH-1:0] in_message_value,
  output logic                     out_valid,
  input  logic                     out_stall,
  output logic [OPERAND_WIDTH-1:0] out_power_result,
  input  logic                     psel,
  input  logic                     penable,
  input  logic                     pwrite,
  input  logic [((OPERAND_WIDTH > 32) ? 4 : 3)-1:0] paddr,
  input  logic [((OPERAND_WIDTH > 32) ? 64 : 32)-1:0] pwdata,
  output logic [((OPERAND_WIDTH > 32) ? 64 : 32)-1:0] prdata,
  output logic                     pready
);

  localparam int W      = OPERAND_WIDTH;
  localparam int DATA_W = (W > 32) ? 64 : 32;
  localparam int ASH    = (W > 32) ? 3 : 2;
  localparam int ADDR_W = ASH + 1;
  localparam int SB_W   = 2 * W;

  logic [W-1:0] modulus_r;
  logic [W-1:0] exponent_r;
  logic         wr_en;
  logic         adv;

  assign pready = 1'b1;
  assign wr_en  = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      modulus_r  <= W'(MODULUS_RESET);
      exponent_r <= W'(EXPONENT_RESET);
    end else if (wr_en) begin
      unique case (int'(paddr[ADDR_W-1:ASH]))
        REG_MODULUS:  modulus_r  <= pwdata[W-1:0];
        REG_EXPONENT: exponent_r <= pwdata[W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (int'(paddr[ADDR_W-1:ASH]))
      REG_MODULUS:  prdata = DATA_W'(modulus_r);
      REG_EXPONENT: prdata = DATA_W'(exponent_r);
      default:      prdata = '0;
    endcase
  end

  logic         out_valid_r;
  logic [W-1:0] out_power_result_r;

  assign adv      = !(out_valid_r && out_stall);
  assign in_stall = !adv;

  // message mod n, restoring, one message bit per stage
  logic         rv_r   [0:W-1];
  logic [W-1:0] rem_r  [0:W-1];
  logic [W-1:0] rmsg_r [0:W-1];
  logic [W-1:0] rn_r   [0:W-1];
  logic [W-1:0] re_r   [0:W-1];

  genvar k;
  generate
    for (k = 0; k < W; k++) begin : g_red
      logic         v_prev;
      logic [W-1:0] rem_prev;
      logic [W-1:0] msg_prev;
      logic [W-1:0] n_prev;
      logic [W-1:0] e_prev;
      logic [W:0]   sh;
      logic [W:0]   df;
      logic [W-1:0] rem_nxt;

      if (k == 0) begin : g_first
        assign v_prev   = in_valid;
        assign rem_prev = '0;
        assign msg_prev = in_message_value;
        assign n_prev   = modulus_r;
        assign e_prev   = exponent_r;
      end else begin : g_next
        assign v_prev   = rv_r[k-1];
        assign rem_prev = rem_r[k-1];
        assign msg_prev = rmsg_r[k-1];
        assign n_prev   = rn_r[k-1];
        assign e_prev   = re_r[k-1];
      end

      always_comb begin
        sh = {rem_prev, msg_prev[W-1-k]};
        df = sh - {1'b0, n_prev};
        if ((n_prev != '0) && (sh >= {1'b0, n_prev})) begin
          rem_nxt = df[W-1:0];
        end else begin
          rem_nxt = sh[W-1:0];
        end
      end

      always_ff @(posedge clk) begin
        if (!rst_n) begin
          rv_r[k] <= 1'b0;
        end else if (adv) begin
          rv_r[k] <= v_prev;
        end
      end

      always_ff @(posedge clk) begin
        if (adv) begin
          rem_r[k]  <= rem_nxt;
          rmsg_r[k] <= msg_prev;
          rn_r[k]   <= n_prev;
          re_r[k]   <= e_prev;
        end
      end
    end
  endgenerate

  // rounds: acc = acc^2 mod n, then acc = acc * (bit ? msg : 1 mod n) mod n
  logic         acc_v   [0:W];
  logic [W-1:0] acc_p   [0:W];
  logic [W-1:0] acc_n   [0:W];
  logic [SB_W-1:0] acc_sb [0:W];

  assign acc_v[0]  = rv_r[W-1];
  assign acc_p[0]  = (rn_r[W-1] == W'(1)) ? '0 : W'(1);
  assign acc_n[0]  = rn_r[W-1];
  assign acc_sb[0] = {rem_r[W-1], re_r[W-1]};

  generate
    for (k = 0; k < W; k++) begin : g_round
      logic            sq_v;
      logic [W-1:0]    sq_p;
      logic [W-1:0]    sq_n;
      logic [SB_W-1:0] sq_sb;
      logic [W-1:0]    one_n;
      logic [W-1:0]    mul_b;

      modexp_mulmod #(
        .WIDTH    (W),
        .SB_WIDTH (SB_W)
      ) u_sq (
        .clk     (clk),
        .rst_n   (rst_n),
        .en      (adv),
        .in_vld  (acc_v[k]),
        .in_a    (acc_p[k]),
        .in_b    (acc_p[k]),
        .in_n    (acc_n[k]),
        .in_sb   (acc_sb[k]),
        .out_vld (sq_v),
        .out_p   (sq_p),
        .out_n   (sq_n),
        .out_sb  (sq_sb)
      );

      assign one_n = (sq_n == W'(1)) ? '0 : W'(1);
      assign mul_b = sq_sb[W-1-k] ? sq_sb[SB_W-1:W] : one_n;

      modexp_mulmod #(
        .WIDTH    (W),
        .SB_WIDTH (SB_W)
      ) u_mul (
        .clk     (clk),
        .rst_n   (rst_n),
        .en      (adv),
        .in_vld  (sq_v),
        .in_a    (sq_p),
        .in_b    (mul_b),
        .in_n    (sq_n),
        .in_sb   (sq_sb),
        .out_vld (acc_v[k+1]),
        .out_p   (acc_p[k+1]),
        .out_n   (acc_n[k+1]),
        .out_sb  (acc_sb[k+1])
      );
    end
  endgenerate

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (adv) begin
      out_valid_r <= acc_v[W];
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      // zero exponent gives 1, unreduced
      out_power_result_r <= (acc_sb[W][W-1:0] == '0) ? W'(1) : acc_p[W];
    end
  end

  assign out_valid        = out_valid_r;
  assign out_power_result = out_power_result_r;

endmodule

[test/tb.sv]
`timescale 1ns / 1ps
module tb;
  import modexp_pkg::*;

  localparam int W = OPERAND_WIDTH_DEF;
  localparam int LATENCY = W + 2 * W * W + 1;

  logic clk;
  logic rst_n;
  logic in_valid;
  logic in_stall;
  logic [W-1:0] in_message_value;
  logic out_valid;
  logic out_stall;
  logic [W-1:0] out_power_result;
  logic psel, penable, pwrite;
  logic [2:0] paddr;
  logic [31:0] pwdata;
  logic [31:0] prdata;
  logic pready;

  modular_exponentiation dut (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_stall(in_stall), .in_message_value(in_message_value),
    .out_valid(out_valid), .out_stall(out_stall), .out_power_result(out_power_result),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .prdata(prdata), .pready(pready)
  );

  logic [W-1:0] modulus_q, exponent_q;
  logic [W-1:0] power_q[$];
  int mismatches;
  int hold_cycles;
  bit drain_hold;

  typedef struct {
    logic [W-1:0] msg;
    bit           known;
    logic [W-1:0] result;
  } vec_t;

  function automatic logic [W-1:0] mulmod(logic [W-1:0] a, logic [W-1:0] b,
                                          logic [W-1:0] n);
    logic [2*W-1:0] p;
    p = a * b;
    if (n == 0) return p[W-1:0];
    return W'(p % n);
  endfunction

  function automatic logic [W-1:0] modpow(logic [W-1:0] msg);
    logic [W-1:0] acc, m;
    int top;
    if (exponent_q == 0) return W'(1);
    m = (modulus_q != 0) ? msg % modulus_q : msg;
    acc = (modulus_q == 1) ? W'(0) : W'(1);
    top = W - 1;
    while (top > 0 && !exponent_q[top]) top--;
    for (int i = top; i >= 0; i--) begin
      acc = mulmod(acc, acc, modulus_q);
      if (exponent_q[i]) acc = mulmod(acc, m, modulus_q);
    end
    return acc;
  endfunction

  initial begin
    clk = 0;
    forever #5 clk = ~clk;
  end

  initial begin
    #100ms;
    $display("Verification failed");
    $finish;
  end

  task automatic reg_write(int idx, logic [W-1:0] val);
    @(negedge clk);
    psel <= 1; penable <= 0; pwrite <= 1; paddr <= 3'(idx * 4); pwdata <= 32'(val);
    @(negedge clk);
    penable <= 1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    @(negedge clk);
    psel <= 0; penable <= 0; pwrite <= 0;
    if (idx == REG_MODULUS) modulus_q = val;
    else if (idx == REG_EXPONENT) exponent_q = val;
  endtask

  task automatic send_message(logic [W-1:0] msg);
    @(negedge clk);
    in_valid <= 1;
    in_message_value <= msg;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    power_q = {power_q, modpow(msg)};
    @(negedge clk);
    in_valid <= 0;
  endtask

  task automatic send_burst(int n, bit dense);
    for (int i = 0; i < n; i++) begin
      send_message(W'($urandom));
      if (!dense && $urandom_range(0, 3) == 0)
        repeat ($urandom_range(1, 20)) @(negedge clk);
    end
  endtask

  task automatic drain();
    int guard;
    guard = 0;
    while (power_q.size() != 0 && guard < 200000) begin
      @(posedge clk);
      guard++;
    end
    repeat (LATENCY + 10) @(posedge clk);
  endtask

  // receiver
  initial begin
    out_stall = 0;
    hold_cycles = 0;
    forever begin
      @(negedge clk);
      if (drain_hold) out_stall <= 1;
      else if (hold_cycles > 0) begin
        hold_cycles--;
        out_stall <= 1;
      end else out_stall <= ($urandom_range(0, 9) < 3);
    end
  end

  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall) begin
      if (power_q.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected beat %h", out_power_result);
      end else begin
        logic [W-1:0] exp_v;
        exp_v = power_q.pop_front();
        if (exp_v !== out_power_result) begin
          mismatches++;
          if (mismatches <= 10)
            $display("power_result mismatch: expected %h actual %h", exp_v,
                     out_power_result);
        end
      end
    end
  end

  vec_t dir[] = '{
    '{16'h0000, 1, 16'h0001}, '{16'hffff, 1, 16'h0001}, '{16'h1234, 1, 16'h0001}
  };

  logic [W-1:0] mods[8] = '{16'd1, 16'hffff, 16'd2, 16'd251, 16'h8000, 16'd0,
                            16'hfffb, 16'd1000};
  logic [W-1:0] exps[8] = '{16'd5, 16'hffff, 16'd1, 16'd3, 16'h8001, 16'hfffe,
                            16'h0000, 16'h1001};

  initial begin
    rst_n = 0; in_valid = 0; in_message_value = 0;
    psel = 0; penable = 0; pwrite = 0; paddr = 0; pwdata = 0;
    mismatches = 0; drain_hold = 0;
    modulus_q = W'(MODULUS_RESET); exponent_q = W'(EXPONENT_RESET);
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst_n = 1;
    // reset state: exponent zero gives one
    foreach (dir[i]) begin
      send_message(dir[i].msg);
      if (dir[i].known && power_q[$] !== dir[i].result) begin
        mismatches++;
        $display("directed predictor mismatch row %0d", i);
      end
    end
    drain();
    reg_write(REG_MODULUS, 16'd2);
    reg_write(REG_EXPONENT, 16'd0);
    send_message(16'hffff);
    drain();
    foreach (mods[k]) begin
      reg_write(REG_MODULUS, mods[k]);
      reg_write(REG_EXPONENT, exps[k]);
      send_message(16'h0000);
      send_message(16'hffff);
      send_message(mods[k]);
      send_message(mods[k] - 1);
      if (k == 2) begin
        hold_cycles = 3 * LATENCY;
        send_burst(300, 1);
      end else send_burst(70, 0);
      drain();
    end
    drain_hold = 0;
    if (mismatches == 0) $display("Verification passed");
    else $display("Verification failed");
    $finish;
  end

endmodule

[modular_exponentiation.f]
hw/rtl/modexp_pkg.sv
hw/rtl/modexp_mulmod.sv
hw/rtl/modular_exponentiation.sv
test/tb.sv
